FILE: rtl/c6502_eu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c6502_eu_pkg
// Operation codes, register types and flag helpers for the 6502 execute unit.
// ----------------------------------------------------------------------------
package c6502_eu_pkg;

  localparam int unsigned ACTION_W = 6;
  localparam int unsigned IN_DATA_W = 16;
  localparam int unsigned OUT_DATA_W = 48;

  // operation codes
  localparam logic [ACTION_W-1:0] OP_LDA   = 6'd0;
  localparam logic [ACTION_W-1:0] OP_LDX   = 6'd1;
  localparam logic [ACTION_W-1:0] OP_LDY   = 6'd2;
  localparam logic [ACTION_W-1:0] OP_TAX   = 6'd3;
  localparam logic [ACTION_W-1:0] OP_INX   = 6'd4;
  localparam logic [ACTION_W-1:0] OP_INY   = 6'd5;
  localparam logic [ACTION_W-1:0] OP_DEX   = 6'd6;
  localparam logic [ACTION_W-1:0] OP_DEY   = 6'd7;
  localparam logic [ACTION_W-1:0] OP_AND   = 6'd8;
  localparam logic [ACTION_W-1:0] OP_EOR   = 6'd9;
  localparam logic [ACTION_W-1:0] OP_ORA   = 6'd10;
  localparam logic [ACTION_W-1:0] OP_ADC   = 6'd11;
  localparam logic [ACTION_W-1:0] OP_SBC   = 6'd12;
  localparam logic [ACTION_W-1:0] OP_ASL_A = 6'd13;
  localparam logic [ACTION_W-1:0] OP_LSR_A = 6'd14;
  localparam logic [ACTION_W-1:0] OP_ROL_A = 6'd15;
  localparam logic [ACTION_W-1:0] OP_ROR_A = 6'd16;
  localparam logic [ACTION_W-1:0] OP_ASL_M = 6'd17;
  localparam logic [ACTION_W-1:0] OP_LSR_M = 6'd18;
  localparam logic [ACTION_W-1:0] OP_ROL_M = 6'd19;
  localparam logic [ACTION_W-1:0] OP_ROR_M = 6'd20;
  localparam logic [ACTION_W-1:0] OP_INC   = 6'd21;
  localparam logic [ACTION_W-1:0] OP_DEC   = 6'd22;
  localparam logic [ACTION_W-1:0] OP_BIT   = 6'd23;
  localparam logic [ACTION_W-1:0] OP_CMP   = 6'd24;
  localparam logic [ACTION_W-1:0] OP_CPX   = 6'd25;
  localparam logic [ACTION_W-1:0] OP_CPY   = 6'd26;
  localparam logic [ACTION_W-1:0] OP_PLA   = 6'd27;
  localparam logic [ACTION_W-1:0] OP_PLP   = 6'd28;
  localparam logic [ACTION_W-1:0] OP_PHP   = 6'd29;
  localparam logic [ACTION_W-1:0] OP_STA   = 6'd30;
  localparam logic [ACTION_W-1:0] OP_SEC   = 6'd31;
  localparam logic [ACTION_W-1:0] OP_CLC   = 6'd32;

  // shift kinds
  localparam logic [1:0] SH_ASL = 2'd0;
  localparam logic [1:0] SH_LSR = 2'd1;
  localparam logic [1:0] SH_ROL = 2'd2;
  localparam logic [1:0] SH_ROR = 2'd3;

  // status bit positions
  localparam int unsigned FLAG_C = 0;
  localparam int unsigned FLAG_Z = 1;
  localparam int unsigned FLAG_B = 4;
  localparam int unsigned FLAG_5 = 5;
  localparam int unsigned FLAG_V = 6;
  localparam int unsigned FLAG_N = 7;

  localparam logic [7:0] FLAGS_RESET = 8'h24;
  localparam logic [7:0] PUSH_MASK   = 8'h30;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] p;
  } regs_t;

  typedef struct packed {
    logic [7:0] wdata;
    logic       we;
  } wr_t;

  localparam regs_t REGS_RESET = '{a: 8'h00, x: 8'h00, y: 8'h00, p: FLAGS_RESET};

  // set z and n from a result byte
  function automatic logic [7:0] set_zn(input logic [7:0] p, input logic [7:0] v);
    logic [7:0] r;
    r = p;
    r[FLAG_Z] = (v == 8'h00);
    r[FLAG_N] = v[7];
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/c6502_eu_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c6502_eu_alu
// Next register state and write-back byte for one operation.
// ----------------------------------------------------------------------------
module c6502_eu_alu
  import c6502_eu_pkg::*;
(
  input  wire logic [ACTION_W-1:0] action,
  input  wire logic [7:0]          operand,
  input  wire regs_t               cur,
  output regs_t                    nxt,
  output wr_t                      wr
);

  logic [7:0] add_m;
  logic [8:0] add_sum;
  logic [7:0] add_res;
  logic       add_v;
  logic [7:0] cmp_reg;
  logic [8:0] cmp_diff;
  logic [7:0] sh_src;
  logic [1:0] sh_kind;
  logic [7:0] sh_res;
  logic       sh_c;
  logic       cin;

  assign cin = cur.p[FLAG_C];

  // sbc is adc of the inverted operand
  assign add_m   = (action == OP_SBC) ? ~operand : operand;
  assign add_sum = {1'b0, cur.a} + {1'b0, add_m} + {8'h00, cin};
  assign add_res = add_sum[7:0];
  assign add_v   = ((cur.a ^ add_res) & (add_m ^ add_res) & 8'h80) != 8'h00;

  always_comb begin
    unique case (action)
      OP_CPX:  cmp_reg = cur.x;
      OP_CPY:  cmp_reg = cur.y;
      default: cmp_reg = cur.a;
    endcase
  end
  assign cmp_diff = {1'b0, cmp_reg} - {1'b0, operand};

  // shifter input and kind: accumulator codes come first, memory codes after
  always_comb begin
    sh_src  = operand;
    sh_kind = SH_ASL;
    unique case (action)
      OP_ASL_A: begin sh_src = cur.a; sh_kind = SH_ASL; end
      OP_LSR_A: begin sh_src = cur.a; sh_kind = SH_LSR; end
      OP_ROL_A: begin sh_src = cur.a; sh_kind = SH_ROL; end
      OP_ROR_A: begin sh_src = cur.a; sh_kind = SH_ROR; end
      OP_LSR_M: sh_kind = SH_LSR;
      OP_ROL_M: sh_kind = SH_ROL;
      OP_ROR_M: sh_kind = SH_ROR;
      default:  sh_kind = SH_ASL;
    endcase
  end

  always_comb begin
    unique case (sh_kind)
      SH_ASL: begin sh_res = {sh_src[6:0], 1'b0}; sh_c = sh_src[7]; end
      SH_LSR: begin sh_res = {1'b0, sh_src[7:1]}; sh_c = sh_src[0]; end
      SH_ROL: begin sh_res = {sh_src[6:0], cin};  sh_c = sh_src[7]; end
      default: begin sh_res = {cin, sh_src[7:1]}; sh_c = sh_src[0]; end
    endcase
  end

  always_comb begin
    nxt      = cur;
    wr.wdata = 8'h00;
    wr.we    = 1'b0;
    unique case (action) inside
      OP_LDA, OP_PLA: begin
        nxt.a = operand;
        nxt.p = set_zn(cur.p, operand);
      end
      OP_LDX: begin
        nxt.x = operand;
        nxt.p = set_zn(cur.p, operand);
      end
      OP_LDY: begin
        nxt.y = operand;
        nxt.p = set_zn(cur.p, operand);
      end
      OP_TAX: begin
        nxt.x = cur.a;
        nxt.p = set_zn(cur.p, cur.a);
      end
      OP_INX: begin
        nxt.x = cur.x + 8'd1;
        nxt.p = set_zn(cur.p, nxt.x);
      end
      OP_INY: begin
        nxt.y = cur.y + 8'd1;
        nxt.p = set_zn(cur.p, nxt.y);
      end
      OP_DEX: begin
        nxt.x = cur.x - 8'd1;
        nxt.p = set_zn(cur.p, nxt.x);
      end
      OP_DEY: begin
        nxt.y = cur.y - 8'd1;
        nxt.p = set_zn(cur.p, nxt.y);
      end
      OP_AND: begin
        nxt.a = cur.a & operand;
        nxt.p = set_zn(cur.p, nxt.a);
      end
      OP_EOR: begin
        nxt.a = cur.a ^ operand;
        nxt.p = set_zn(cur.p, nxt.a);
      end
      OP_ORA: begin
        nxt.a = cur.a | operand;
        nxt.p = set_zn(cur.p, nxt.a);
      end
      OP_ADC, OP_SBC: begin
        nxt.a         = add_res;
        nxt.p         = set_zn(cur.p, add_res);
        nxt.p[FLAG_C] = add_sum[8];
        nxt.p[FLAG_V] = add_v;
      end
      [OP_ASL_A:OP_ROR_A]: begin
        nxt.a         = sh_res;
        nxt.p         = set_zn(cur.p, sh_res);
        nxt.p[FLAG_C] = sh_c;
      end
      [OP_ASL_M:OP_ROR_M]: begin
        nxt.p         = set_zn(cur.p, sh_res);
        nxt.p[FLAG_C] = sh_c;
        wr.wdata      = sh_res;
        wr.we         = 1'b1;
      end
      OP_INC: begin
        wr.wdata = operand + 8'd1;
        wr.we    = 1'b1;
        nxt.p    = set_zn(cur.p, wr.wdata);
      end
      OP_DEC: begin
        wr.wdata = operand - 8'd1;
        wr.we    = 1'b1;
        nxt.p    = set_zn(cur.p, wr.wdata);
      end
      OP_BIT: begin
        nxt.p[FLAG_Z] = (cur.a & operand) == 8'h00;
        nxt.p[FLAG_N] = operand[7];
        nxt.p[FLAG_V] = operand[6];
      end
      OP_CMP, OP_CPX, OP_CPY: begin
        nxt.p         = set_zn(cur.p, cmp_diff[7:0]);
        nxt.p[FLAG_C] = ~cmp_diff[8];
      end
      OP_PLP: begin
        nxt.p         = operand;
        nxt.p[FLAG_B] = 1'b0;
        nxt.p[FLAG_5] = 1'b1;
      end
      OP_PHP: begin
        wr.wdata = cur.p | PUSH_MASK;
        wr.we    = 1'b1;
      end
      OP_STA: begin
        wr.wdata = cur.a;
        wr.we    = 1'b1;
      end
      OP_SEC:  nxt.p[FLAG_C] = 1'b1;
      OP_CLC:  nxt.p[FLAG_C] = 1'b0;
      default: nxt = cur;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/cpu_6502_execute_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// each accepted word passes the input register, the ALU, then the result register
// throughput: one word per cycle, limited only by out_tready
// the input register and the result register are separate, so a new word is
// taken while a finished result still waits downstream
// reset: a, x, y clear to zero, status to 0x24, both pipeline registers empty
// ----------------------------------------------------------------------------
// cpu_6502_execute_unit
// Binary-only 6502 data path: one operation per word on kept A, X, Y, P.
// ----------------------------------------------------------------------------
module cpu_6502_execute_unit
  import c6502_eu_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // action[5:0], operand[13:6]
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata   // write_data[7:0], write_enable[8],
                                                 // status_out[16:9], acc_out[24:17],
                                                 // x_out[32:25], y_out[40:33]
);

  logic                  in_valid_r;
  logic [ACTION_W-1:0]   action_r;
  logic [7:0]            operand_r;
  regs_t                 regs_r;
  regs_t                 regs_nxt;
  wr_t                   wr_nxt;
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_DATA_W-1:0] out_data_nxt;
  logic                  advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  c6502_eu_alu u_alu (
    .action  (action_r),
    .operand (operand_r),
    .cur     (regs_r),
    .nxt     (regs_nxt),
    .wr      (wr_nxt)
  );

  assign out_data_nxt = {7'd0, regs_nxt.y, regs_nxt.x, regs_nxt.a, regs_nxt.p,
                         wr_nxt.we, wr_nxt.wdata};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      regs_r      <= REGS_RESET;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        regs_r      <= regs_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      action_r  <= in_tdata[5:0];
      operand_r <= in_tdata[13:6];
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

FILE: rtl/c6502_eu_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c6502_eu_checker
// Port-level checks for the execute unit, bound to the top level.
// ----------------------------------------------------------------------------
module c6502_eu_checker
  import c6502_eu_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // status bit5 always reads as one
  a_bit5_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[14])
    else $error("status bit5 clear");

  // only a push sets b, and that is in write data, never in the kept status
  a_b_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[13])
    else $error("status b set");

  // no write means zero write data
  a_wdata_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[8] |-> out_tdata[7:0] == 8'h00)
    else $error("write data nonzero without write enable");

  // nothing leaves the block in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind cpu_6502_execute_unit c6502_eu_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

FILE: test/tb_cpu_6502_execute_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cpu_6502_execute_unit
// Self-checking bench for the 6502 execute unit. A directed table covers
// every operation, the byte extremes, the status pull and push, and an
// unused code. A long random run follows with bursty stalls on both
// streams. Every result word is checked against an in-bench model of
// A, X, Y and P, or against the word given in the table for a typed row.
// ----------------------------------------------------------------------------
module tb_cpu_6502_execute_unit;
  import c6502_eu_pkg::*;

  localparam int unsigned RANDOM_OPS = 750;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned NUM_DIRECTED = 38;
  localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = 6'd33;
  localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = 6'd63;

  // packs like out_tdata[40:0]
  typedef struct packed {
    logic [7:0] y;
    logic [7:0] x;
    logic [7:0] a;
    logic [7:0] p;
    logic       we;
    logic [7:0] wd;
  } result_t;

  typedef struct packed {
    logic [ACTION_W-1:0] act;
    logic [7:0]          opd;
    bit                  typed;
    result_t             want;
  } op_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  // model registers
  logic [7:0] model_a;
  logic [7:0] model_x;
  logic [7:0] model_y;
  logic [7:0] model_p;

  result_t predicted_words[$];
  int unsigned mismatches;
  int unsigned stall_cycles;
  bit calm;

  cpu_6502_execute_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // typed rows follow from the register values reached just before them
  op_row_t directed_rows[NUM_DIRECTED] = '{
    '{OP_CLC, 8'h00, 1'b1, '{wd: 8'h00, we: 1'b0, p: 8'h24, a: 8'h00, x: 8'h00, y: 8'h00}},
    '{OP_LDA, 8'hFF, 1'b1, '{wd: 8'h00, we: 1'b0, p: 8'hA4, a: 8'hFF, x: 8'h00, y: 8'h00}},
    '{OP_STA, 8'h5A, 1'b1, '{wd: 8'hFF, we: 1'b1, p: 8'hA4, a: 8'hFF, x: 8'h00, y: 8'h00}},
    '{OP_LDX, 8'h80, 1'b1, '{wd: 8'h00, we: 1'b0, p: 8'hA4, a: 8'hFF, x: 8'h80, y: 8'h00}},
    '{OP_LDY, 8'h00, 1'b1, '{wd: 8'h00, we: 1'b0, p: 8'h26, a: 8'hFF, x: 8'h80, y: 8'h00}},
    '{OP_ADC, 8'h01, 1'b1, '{wd: 8'h00, we: 1'b0, p: 8'h27, a: 8'h00, x: 8'h80, y: 8'h00}},
    '{OP_LDA, 8'h7F, 1'b0, '0},
    '{OP_ADC, 8'h00, 1'b0, '0},
    '{OP_SBC, 8'hFF, 1'b0, '0},
    '{OP_AND, 8'h0F, 1'b0, '0},
    '{OP_EOR, 8'hFF, 1'b0, '0},
    '{OP_ORA, 8'h81, 1'b0, '0},
    '{OP_TAX, 8'h00, 1'b0, '0},
    '{OP_INX, 8'hFF, 1'b0, '0},
    '{OP_INY, 8'h00, 1'b0, '0},
    '{OP_DEX, 8'h00, 1'b0, '0},
    '{OP_DEY, 8'h00, 1'b0, '0},
    '{OP_ASL_A, 8'h00, 1'b0, '0},
    '{OP_LSR_A, 8'h00, 1'b0, '0},
    '{OP_ROL_A, 8'h00, 1'b0, '0},
    '{OP_ROR_A, 8'h00, 1'b0, '0},
    '{OP_ASL_M, 8'h80, 1'b0, '0},
    '{OP_LSR_M, 8'h01, 1'b0, '0},
    '{OP_ROL_M, 8'hFF, 1'b0, '0},
    '{OP_ROR_M, 8'h01, 1'b0, '0},
    '{OP_INC, 8'hFF, 1'b0, '0},
    '{OP_DEC, 8'h00, 1'b0, '0},
    '{OP_BIT, 8'hC0, 1'b0, '0},
    '{OP_CMP, 8'h7F, 1'b0, '0},
    '{OP_CPX, 8'hFF, 1'b0, '0},
    '{OP_CPY, 8'h00, 1'b0, '0},
    '{OP_PLA, 8'h00, 1'b0, '0},
    '{OP_PLP, 8'hFF, 1'b0, '0},
    '{OP_PHP, 8'h00, 1'b0, '0},
    '{OP_PLP, 8'h00, 1'b0, '0},
    '{OP_PHP, 8'h00, 1'b0, '0},
    '{OP_SEC, 8'h00, 1'b0, '0},
    '{ACT_UNUSED_HI, 8'hFF, 1'b0, '0}
  };

  function automatic logic [7:0] with_zn(input logic [7:0] v);
    model_p[FLAG_Z] = (v == 8'h00);
    model_p[FLAG_N] = v[7];
    return v;
  endfunction

  function automatic void add_carry(input logic [7:0] m);
    logic [8:0] sum;
    logic [7:0] r;
    logic [7:0] ovf;
    sum = {1'b0, model_a} + {1'b0, m} + {8'h00, model_p[FLAG_C]};
    r = sum[7:0];
    ovf = (model_a ^ r) & (m ^ r);
    model_p[FLAG_C] = sum[8];
    model_p[FLAG_V] = ovf[7];
    model_a = with_zn(r);
  endfunction

  function automatic void model_compare(input logic [7:0] r, input logic [7:0] m);
    model_p[FLAG_C] = (r >= m);
    void'(with_zn(r - m));
  endfunction

  function automatic logic [7:0] shift_byte(input logic [5:0] ofs, input logic [7:0] v);
    logic       cin;
    logic [7:0] r;
    cin = model_p[FLAG_C];
    case (ofs[1:0])
      SH_ASL: begin
        model_p[FLAG_C] = v[7];
        r = {v[6:0], 1'b0};
      end
      SH_LSR: begin
        model_p[FLAG_C] = v[0];
        r = {1'b0, v[7:1]};
      end
      SH_ROL: begin
        model_p[FLAG_C] = v[7];
        r = {v[6:0], cin};
      end
      default: begin
        model_p[FLAG_C] = v[0];
        r = {cin, v[7:1]};
      end
    endcase
    return with_zn(r);
  endfunction

  // applies one operation to the model registers, returns the result word
  function automatic result_t exec_6502_op(input logic [ACTION_W-1:0] act,
                                           input logic [7:0] m);
    result_t res;
    res = '0;
    case (act)
      OP_LDA, OP_PLA: model_a = with_zn(m);
      OP_LDX: model_x = with_zn(m);
      OP_LDY: model_y = with_zn(m);
      OP_TAX: model_x = with_zn(model_a);
      OP_INX: model_x = with_zn(model_x + 8'd1);
      OP_INY: model_y = with_zn(model_y + 8'd1);
      OP_DEX: model_x = with_zn(model_x - 8'd1);
      OP_DEY: model_y = with_zn(model_y - 8'd1);
      OP_AND: model_a = with_zn(model_a & m);
      OP_EOR: model_a = with_zn(model_a ^ m);
      OP_ORA: model_a = with_zn(model_a | m);
      OP_ADC: add_carry(m);
      OP_SBC: add_carry(~m);
      OP_ASL_A, OP_LSR_A, OP_ROL_A, OP_ROR_A:
        model_a = shift_byte(act - OP_ASL_A, model_a);
      OP_ASL_M, OP_LSR_M, OP_ROL_M, OP_ROR_M: begin
        res.wd = shift_byte(act - OP_ASL_M, m);
        res.we = 1'b1;
      end
      OP_INC: begin
        res.wd = with_zn(m + 8'd1);
        res.we = 1'b1;
      end
      OP_DEC: begin
        res.wd = with_zn(m - 8'd1);
        res.we = 1'b1;
      end
      OP_BIT: begin
        model_p[FLAG_Z] = ((model_a & m) == 8'h00);
        model_p[FLAG_N] = m[7];
        model_p[FLAG_V] = m[6];
      end
      OP_CMP: model_compare(model_a, m);
      OP_CPX: model_compare(model_x, m);
      OP_CPY: model_compare(model_y, m);
      OP_PLP: begin
        model_p = m;
        model_p[FLAG_B] = 1'b0;
        model_p[FLAG_5] = 1'b1;
      end
      OP_PHP: begin
        res.wd = model_p | PUSH_MASK;
        res.we = 1'b1;
      end
      OP_STA: begin
        res.wd = model_a;
        res.we = 1'b1;
      end
      OP_SEC: model_p[FLAG_C] = 1'b1;
      OP_CLC: model_p[FLAG_C] = 1'b0;
      default: ;
    endcase
    res.p = model_p;
    res.a = model_a;
    res.x = model_x;
    res.y = model_y;
    return res;
  endfunction

  // holds the word until accepted, then predicts its result
  task automatic send_op(input logic [ACTION_W-1:0] act, input logic [7:0] opd,
                         input bit typed, input result_t want);
    result_t calc;
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, opd, act};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    calc = exec_6502_op(act, opd);
    predicted_words.push_back(typed ? want : calc);
  endtask

  task automatic hold_off(input int unsigned cycles);
    in_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_operand();
    logic [7:0] corners[5] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFF};
    if ($urandom_range(0, 3) == 0) begin
      return corners[$urandom_range(0, 4)];
    end
    return 8'($urandom);
  endfunction

  // result side
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[40:0];
      if (predicted_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result word %h", out_tdata);
        end
      end else begin
        want = predicted_words.pop_front();
        if (got !== want || out_tdata[47:41] !== 7'd0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp wd=%h we=%b p=%h a=%h x=%h y=%h",
                     want.wd, want.we, want.p, want.a, want.x, want.y);
            $display("          got wd=%h we=%b p=%h a=%h x=%h y=%h pad=%h",
                     got.wd, got.we, got.p, got.a, got.x, got.y, out_tdata[47:41]);
          end
        end
      end
    end
  end

  // watchdog on stalled handshakes
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // downstream backpressure in bursts
  initial begin
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  initial begin
    int unsigned sent;
    int unsigned gap_pct;
    logic [ACTION_W-1:0] act;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    mismatches = 0;
    calm = 1'b0;
    model_a = REGS_RESET.a;
    model_x = REGS_RESET.x;
    model_y = REGS_RESET.y;
    model_p = REGS_RESET.p;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_op(directed_rows[i].act, directed_rows[i].opd,
              directed_rows[i].typed, directed_rows[i].want);
      if ($urandom_range(0, 3) == 0) begin
        hold_off($urandom_range(1, 14));
      end
    end

    sent = 0;
    gap_pct = 0;
    while (sent < RANDOM_OPS) begin
      // idle density changes every 50 words, sometimes none at all
      if (sent % 50 == 0) begin
        gap_pct = 25 * $urandom_range(0, 2);
      end
      if (sent == RANDOM_OPS / 3) begin
        // let the pipe drain completely once
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (predicted_words.size() != 0) @(posedge clk);
      end
      if (sent >= RANDOM_OPS - 100) begin
        calm = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) begin
        act = ACTION_W'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
      end else begin
        act = ACTION_W'($urandom_range(OP_LDA, OP_CLC));
      end
      sent++;
      send_op(act, pick_operand(), 1'b0, '0);
      if (!calm && $urandom_range(1, 100) <= gap_pct) begin
        hold_off($urandom_range(1, 14));
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (predicted_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && predicted_words.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
